// ===== rtl/lpgb_pkg.sv =====
// ----------------------------------------------------------------------------
// lpgb_pkg
// Shared constants for the polar grid binner: register map, phase format
// and the arctangent table of the phase units.
// ----------------------------------------------------------------------------
package lpgb_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_MIN_RSQ  = 3'd0;
    localparam logic [2:0] REG_MAX_RSQ  = 3'd1;
    localparam logic [2:0] REG_SENS_H   = 3'd2;
    localparam logic [2:0] REG_START    = 3'd3;
    localparam logic [2:0] REG_STEP     = 3'd4;
    localparam logic [2:0] REG_FAR      = 3'd5;
    localparam logic [2:0] REG_SECTORS  = 3'd6;
    localparam logic [2:0] REG_BINS     = 3'd7;

    // phase accumulator: 2^32 per full turn, with headroom and sign
    localparam int ZW = 34;
    localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sh0_4000_0000;
    localparam logic signed [ZW-1:0] HALF_TURN    = 34'sh0_8000_0000;
    localparam logic signed [ZW-1:0] FULL_TURN    = 34'sh1_0000_0000;

    // centidegrees per full turn
    localparam logic signed [16:0] CDEG_TURN = 17'sd36000;

    // arctangent of 2^-i in 2^32 per turn
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] a;
        case (i)
            0:       a = 32'h20000000;
            1:       a = 32'h12E4051E;
            2:       a = 32'h09FB385B;
            3:       a = 32'h051111D4;
            4:       a = 32'h028B0D43;
            5:       a = 32'h0145D7E1;
            6:       a = 32'h00A2F61E;
            7:       a = 32'h00517C55;
            8:       a = 32'h0028BE53;
            9:       a = 32'h00145F2F;
            10:      a = 32'h000A2F98;
            11:      a = 32'h000517CC;
            12:      a = 32'h00028BE6;
            13:      a = 32'h000145F3;
            14:      a = 32'h0000A2FA;
            15:      a = 32'h0000517D;
            16:      a = 32'h000028BE;
            17:      a = 32'h0000145F;
            18:      a = 32'h00000A30;
            19:      a = 32'h00000518;
            20:      a = 32'h0000028C;
            21:      a = 32'h00000146;
            22:      a = 32'h000000A3;
            23:      a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/lidar_polar_grid_binner.sv =====
// ----------------------------------------------------------------------------
// lidar_polar_grid_binner
// Maps one lidar point to its azimuth sector and elevation bin, with range
// gating, floored ground range and height pass-through.
// ----------------------------------------------------------------------------
//  channel   direction  signals                                   transfer
//  point     in         start, busy, pos_x, pos_y, pos_z          start & !busy
//  result    out        done, in_range, sector, bin, bin_bad,     done
//                       ground_range, height
//  config    in/out     psel, penable, pwrite, paddr, pwdata,     psel & penable
//                       prdata, pready                            & pwrite
//
//  one point per clock; busy is always low
//  points pass through the square root pipeline (one bit a stage), the two
//  phase pipelines and the bin divider
//  results appear in input order, one done pulse per point
//  rst_n clears all valid bits and loads the register reset values
// ----------------------------------------------------------------------------
module lidar_polar_grid_binner #(
    parameter int COORD_BITS      = 18,
    parameter int ATAN_ITERATIONS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic signed [COORD_BITS-1:0] pos_z,
    output logic                         done,
    output logic                         in_range,
    output logic [11:0]                  sector,
    output logic [9:0]                   bin,
    output logic                         bin_bad,
    output logic [17:0]                  ground_range,
    output logic signed [17:0]           height,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [5:0]                   paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready
);
    import lpgb_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int R     = CB + 8;
    localparam int RSW   = 2 * CB;
    localparam int CMPW  = (RSW > 35) ? RSW : 35;
    localparam int FW    = (RSW > 36) ? RSW : 36;
    localparam int GW    = (CB > 18) ? CB : 18;
    localparam int EW    = (R + 1 > 23) ? R + 1 : 23;
    localparam int NW    = 54;
    localparam int DW    = 17;
    localparam int SQ_SW = 3 * CB + 2;
    localparam int AZ_SW = R + CB + 2;
    localparam int EL_SW = 12 + 18 + CB + 2;
    localparam int DV_SW = 1 + 12 + 18 + CB + 1;

    // configuration registers
    logic [34:0] min_rsq_reg;
    logic [34:0] max_rsq_reg;
    logic [13:0] sens_h_reg;
    logic [13:0] start_reg;
    logic [13:0] step_reg;
    logic [17:0] far_reg;
    logic [12:0] sectors_reg;
    logic [10:0] bins_reg;
    logic [35:0] far_sq_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel & penable & pwrite & pready;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_rsq_reg <= 35'd0;
            max_rsq_reg <= 35'd2500000000;
            sens_h_reg  <= 14'd1800;
            start_reg   <= 14'd0;
            step_reg    <= 14'd40;
            far_reg     <= 18'd20000;
            sectors_reg <= 13'd360;
            bins_reg    <= 11'd64;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[5:3])
                REG_MIN_RSQ: min_rsq_reg <= pwdata[34:0];
                REG_MAX_RSQ: max_rsq_reg <= pwdata[34:0];
                REG_SENS_H:  sens_h_reg  <= pwdata[13:0];
                REG_START:   start_reg   <= pwdata[13:0];
                REG_STEP:    step_reg    <= pwdata[13:0];
                REG_FAR:     far_reg     <= pwdata[17:0];
                REG_SECTORS: sectors_reg <= pwdata[12:0];
                REG_BINS:    bins_reg    <= pwdata[10:0];
                default:     ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (paddr[5:3])
            REG_MIN_RSQ: prdata = 64'(min_rsq_reg);
            REG_MAX_RSQ: prdata = 64'(max_rsq_reg);
            REG_SENS_H:  prdata = 64'(sens_h_reg);
            REG_START:   prdata = 64'(start_reg);
            REG_STEP:    prdata = 64'(step_reg);
            REG_FAR:     prdata = 64'(far_reg);
            REG_SECTORS: prdata = 64'(sectors_reg);
            REG_BINS:    prdata = 64'(bins_reg);
            default:     prdata = '0;
        endcase
    end

    // derived settings
    logic [12:0] sc_eff;
    logic [10:0] bc_eff;
    logic [13:0] st_eff;

    assign sc_eff = (sectors_reg > 13'd4096) ? 13'd4096 : sectors_reg;
    assign bc_eff = (bins_reg > 11'd1024) ? 11'd1024 : bins_reg;
    assign st_eff = (step_reg == 14'd0) ? 14'd1 : step_reg;

    always_ff @(posedge clk)
    begin
        far_sq_reg <= far_reg * far_reg;
    end

    // stage a: point capture
    logic                 a_valid_reg;
    logic signed [CB-1:0] a_x_reg;
    logic signed [CB-1:0] a_y_reg;
    logic signed [CB-1:0] a_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        a_x_reg <= pos_x;
        a_y_reg <= pos_y;
        a_z_reg <= pos_z;
    end

    // stage b: squares
    logic                  b_valid_reg;
    logic signed [RSW-1:0] b_xx_reg;
    logic signed [RSW-1:0] b_yy_reg;
    logic signed [CB-1:0]  b_x_reg;
    logic signed [CB-1:0]  b_y_reg;
    logic signed [CB-1:0]  b_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_xx_reg <= a_x_reg * a_x_reg;
        b_yy_reg <= a_y_reg * a_y_reg;
        b_x_reg  <= a_x_reg;
        b_y_reg  <= a_y_reg;
        b_z_reg  <= a_z_reg;
    end

    // stage c: squared ground range
    logic                 c_valid_reg;
    logic [RSW-1:0]       c_rs_reg;
    logic signed [CB-1:0] c_x_reg;
    logic signed [CB-1:0] c_y_reg;
    logic signed [CB-1:0] c_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_rs_reg <= $unsigned(b_xx_reg) + $unsigned(b_yy_reg);
        c_x_reg  <= b_x_reg;
        c_y_reg  <= b_y_reg;
        c_z_reg  <= b_z_reg;
    end

    // stage d: range gate and far flag
    logic                 d_valid_reg;
    logic [RSW-1:0]       d_rs_reg;
    logic                 d_inr_reg;
    logic                 d_far_reg;
    logic signed [CB-1:0] d_x_reg;
    logic signed [CB-1:0] d_y_reg;
    logic signed [CB-1:0] d_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_rs_reg  <= c_rs_reg;
        d_inr_reg <= (CMPW'(c_rs_reg) < CMPW'(max_rsq_reg))
                   && (CMPW'(c_rs_reg) > CMPW'(min_rsq_reg));
        d_far_reg <= (FW'(c_rs_reg) >= FW'(far_sq_reg));
        d_x_reg   <= c_x_reg;
        d_y_reg   <= c_y_reg;
        d_z_reg   <= c_z_reg;
    end

    // ground range with 8 fraction bits
    logic               sq_valid;
    logic [R-1:0]       sq_root;
    logic [SQ_SW-1:0]   sq_side;

    lpgb_sqrt #(
        .R  (R),
        .SW (SQ_SW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid_reg),
        .in_val    ({d_rs_reg, 16'h0000}),
        .in_side   ({d_x_reg, d_y_reg, d_z_reg, d_inr_reg, d_far_reg}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    logic signed [CB-1:0] sq_x;
    logic signed [CB-1:0] sq_y;
    logic [CB-1:0]        sq_z;
    logic                 sq_inr;
    logic                 sq_far;

    assign {sq_x, sq_y, sq_z, sq_inr, sq_far} = sq_side;

    // azimuth phase
    logic              az_valid;
    logic signed [ZW-1:0] az_z;
    logic [AZ_SW-1:0]  az_side;

    lpgb_cordic #(
        .IN_W   (CB + 8),
        .STAGES (ATAN_ITERATIONS),
        .SW     (AZ_SW)
    ) u_az (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_x      ($signed({sq_x, 8'h00})),
        .in_y      ($signed({sq_y, 8'h00})),
        .in_side   ({sq_root, sq_z, sq_inr, sq_far}),
        .out_valid (az_valid),
        .out_z     (az_z),
        .out_side  (az_side)
    );

    // stage p: sector product
    logic signed [ZW-1:0] p_shift;
    logic [32:0]          p_clamp;
    logic                 p_valid_reg;
    logic [45:0]          p_prod_reg;
    logic [AZ_SW-1:0]     p_side_reg;

    assign p_shift = az_z + HALF_TURN;

    always_comb
    begin
        if (p_shift < 0)
        begin
            p_clamp = 33'd0;
        end
        else if (p_shift > FULL_TURN)
        begin
            p_clamp = 33'h1_0000_0000;
        end
        else
        begin
            p_clamp = p_shift[32:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= az_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        p_prod_reg <= p_clamp * sc_eff;
        p_side_reg <= az_side;
    end

    logic [R-1:0]  p_rq8;
    logic [CB-1:0] p_z;
    logic          p_inr;
    logic          p_far;
    logic [13:0]   p_sec14;
    logic [11:0]   p_sector;
    logic [GW-1:0] p_grw;
    logic [17:0]   p_gr;

    assign {p_rq8, p_z, p_inr, p_far} = p_side_reg;

    // seam wrap of the sector
    assign p_sec14  = p_prod_reg[45:32];
    assign p_sector = (p_sec14 >= {1'b0, sc_eff}) ? 12'd0 : p_sec14[11:0];

    // floored ground range, saturated to 18 bits
    assign p_grw = GW'(p_rq8[R-1:8]);
    assign p_gr  = (p_grw > GW'(18'h3FFFF)) ? 18'h3FFFF : p_grw[17:0];

    // elevation phase
    logic                 el_valid;
    logic signed [ZW-1:0] el_z;
    logic [EL_SW-1:0]     el_side;

    lpgb_cordic #(
        .IN_W   (EW),
        .STAGES (ATAN_ITERATIONS),
        .SW     (EL_SW)
    ) u_el (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid_reg),
        .in_x      ($signed(EW'({sens_h_reg, 8'h00}))),
        .in_y      ($signed(EW'(p_rq8))),
        .in_side   ({p_sector, p_gr, p_z, p_inr, p_far}),
        .out_valid (el_valid),
        .out_z     (el_z),
        .out_side  (el_side)
    );

    // stage e1: elevation in centidegree scale
    logic                 e1_valid_reg;
    logic signed [50:0]   e1_cd_reg;
    logic [EL_SW-1:0]     e1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg <= 1'b0;
        end
        else
        begin
            e1_valid_reg <= el_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        e1_cd_reg   <= el_z * CDEG_TURN;
        e1_side_reg <= el_side;
    end

    logic [11:0]   e1_sector;
    logic [17:0]   e1_gr;
    logic [CB-1:0] e1_z;
    logic          e1_inr;
    logic          e1_far;

    assign {e1_sector, e1_gr, e1_z, e1_inr, e1_far} = e1_side_reg;

    // stage e2: offset from bin zero, doubled when far
    logic signed [NW-1:0] e2_diff;
    logic                 e2_valid_reg;
    logic signed [NW-1:0] e2_n_reg;
    logic [11:0]          e2_sector_reg;
    logic [17:0]          e2_gr_reg;
    logic [CB-1:0]        e2_z_reg;
    logic                 e2_inr_reg;

    assign e2_diff = NW'(e1_cd_reg) - $signed({8'h00, start_reg, 32'h0000_0000});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e2_valid_reg <= 1'b0;
        end
        else
        begin
            e2_valid_reg <= e1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e2_n_reg      <= e1_far ? (e2_diff <<< 1) : e2_diff;
        e2_sector_reg <= e1_sector;
        e2_gr_reg     <= e1_gr;
        e2_z_reg      <= e1_z;
        e2_inr_reg    <= e1_inr;
    end

    // bin quotient
    logic              dv_valid;
    logic [DW-1:0]     dv_quot;
    logic [DV_SW-1:0]  dv_side;

    lpgb_div #(
        .DW  (DW),
        .DVW (14),
        .SW  (DV_SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .divisor   (st_eff),
        .in_valid  (e2_valid_reg),
        .in_num    (e2_n_reg[48:32]),
        .in_side   ({e2_n_reg[NW-1], e2_sector_reg, e2_gr_reg, e2_z_reg, e2_inr_reg}),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_side  (dv_side)
    );

    logic          dv_neg;
    logic [11:0]   dv_sector;
    logic [17:0]   dv_gr;
    logic [CB-1:0] dv_z;
    logic          dv_inr;
    logic          dv_bad;
    logic [GW-1:0] dv_zw;

    assign {dv_neg, dv_sector, dv_gr, dv_z, dv_inr} = dv_side;
    assign dv_bad = dv_neg || (dv_quot >= DW'(bc_eff));
    assign dv_zw  = GW'(dv_z);

    // result register
    logic        done_reg;
    logic        inr_reg;
    logic [11:0] sector_reg;
    logic [9:0]  bin_reg;
    logic        bad_reg;
    logic [17:0] gr_reg;
    logic [17:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        inr_reg    <= dv_inr;
        sector_reg <= dv_inr ? dv_sector : 12'd0;
        bin_reg    <= (dv_inr && !dv_bad) ? dv_quot[9:0] : 10'd0;
        bad_reg    <= dv_inr && dv_bad;
        gr_reg     <= dv_gr;
        height_reg <= dv_zw[17:0];
    end

    assign done         = done_reg;
    assign in_range     = inr_reg;
    assign sector       = sector_reg;
    assign bin          = bin_reg;
    assign bin_bad      = bad_reg;
    assign ground_range = gr_reg;
    assign height       = $signed(height_reg);

    // out-of-range points carry no grid cell
    a_out_of_range_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_range) |-> (sector == 12'd0 && bin == 10'd0 && !bin_bad))
        else $error("out-of-range point carries a grid cell");

    // a flagged bin reads as zero
    a_bad_bin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bin_bad) |-> (bin == 10'd0))
        else $error("flagged bin is not zero");

    // sector stays below the sector count
    a_sector_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (done && in_range && sc_eff != 13'd0) |-> ({1'b0, sector} < sc_eff))
        else $error("sector not below sector count");

    // good bins stay below the bin count
    a_bin_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (done && in_range && !bin_bad) |-> ({1'b0, bin} < bc_eff))
        else $error("bin not below bin count");

endmodule

// ===== rtl/lpgb_sqrt.sv =====
// ----------------------------------------------------------------------------
// lpgb_sqrt
// Pipelined integer square root, one result bit per stage, with a
// sideband that travels alongside.
// ----------------------------------------------------------------------------
module lpgb_sqrt #(
    parameter int R  = 26,
    parameter int SW = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [2*R-1:0]   in_val,
    input  logic [SW-1:0]    in_side,
    output logic             out_valid,
    output logic [R-1:0]     out_root,
    output logic [SW-1:0]    out_side
);
    localparam int VW = 2 * R;
    localparam int RW = R + 2;

    logic [R:0]    valid_reg;
    logic [VW-1:0] val_reg  [0:R];
    logic [RW-1:0] rem_reg  [0:R];
    logic [R-1:0]  root_reg [0:R];
    logic [SW-1:0] side_reg [0:R];

    // entry stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg[0]  <= in_val;
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        side_reg[0] <= in_side;
    end

    // one root bit per stage
    for (genvar k = 0; k < R; k++) begin : g_step
        logic [RW-1:0] cur;
        logic [RW-1:0] trial;
        logic          take;

        assign cur   = {rem_reg[k][RW-3:0], val_reg[k][VW-1:VW-2]};
        assign trial = RW'({root_reg[k], 2'b01});
        assign take  = (cur >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            val_reg[k+1]  <= {val_reg[k][VW-3:0], 2'b00};
            rem_reg[k+1]  <= take ? (cur - trial) : cur;
            root_reg[k+1] <= {root_reg[k][R-2:0], take};
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = valid_reg[R];
    assign out_root  = root_reg[R];
    assign out_side  = side_reg[R];

endmodule

// ===== rtl/lpgb_cordic.sv =====
// ----------------------------------------------------------------------------
// lpgb_cordic
// Pipelined vectoring phase unit: quarter-turn pre-rotation, then one
// micro-rotation per stage; phase in 2^32 per turn.
// ----------------------------------------------------------------------------
module lpgb_cordic #(
    parameter int IN_W   = 26,
    parameter int STAGES = 16,
    parameter int SW     = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic signed [IN_W-1:0]         in_x,
    input  logic signed [IN_W-1:0]         in_y,
    input  logic [SW-1:0]                  in_side,
    output logic                           out_valid,
    output logic signed [lpgb_pkg::ZW-1:0] out_z,
    output logic [SW-1:0]                  out_side
);
    import lpgb_pkg::*;

    localparam int W = IN_W + 2;

    logic [STAGES:0]       valid_reg;
    logic signed [W-1:0]   x_reg    [0:STAGES];
    logic signed [W-1:0]   y_reg    [0:STAGES];
    logic signed [ZW-1:0]  z_reg    [0:STAGES];
    logic [SW-1:0]         side_reg [0:STAGES];

    logic signed [W-1:0]   xi;
    logic signed [W-1:0]   yi;
    logic signed [W-1:0]   x_next;
    logic signed [W-1:0]   y_next;
    logic signed [ZW-1:0]  z_next;

    // pre-rotation into the right half plane
    assign xi = W'(in_x);
    assign yi = W'(in_y);

    always_comb
    begin
        x_next = xi;
        y_next = yi;
        z_next = '0;
        if (xi < 0)
        begin
            if (yi >= 0)
            begin
                x_next = yi;
                y_next = -xi;
                z_next = QUARTER_TURN;
            end
            else
            begin
                x_next = -yi;
                y_next = xi;
                z_next = -QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x_next;
        y_reg[0]    <= y_next;
        z_reg[0]    <= z_next;
        side_reg[0] <= in_side;
    end

    // micro-rotations
    for (genvar k = 0; k < STAGES; k++) begin : g_rot
        localparam logic signed [ZW-1:0] ANG = {2'b00, atan_turn(k)};
        logic signed [W-1:0] dx;
        logic signed [W-1:0] dy;

        assign dx = y_reg[k] >>> k;
        assign dy = x_reg[k] >>> k;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (y_reg[k] > 0)
            begin
                x_reg[k+1] <= x_reg[k] + dx;
                y_reg[k+1] <= y_reg[k] - dy;
                z_reg[k+1] <= z_reg[k] + ANG;
            end
            else
            begin
                x_reg[k+1] <= x_reg[k] - dx;
                y_reg[k+1] <= y_reg[k] + dy;
                z_reg[k+1] <= z_reg[k] - ANG;
            end
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = valid_reg[STAGES];
    assign out_z     = z_reg[STAGES];
    assign out_side  = side_reg[STAGES];

endmodule

// ===== rtl/lpgb_div.sv =====
// ----------------------------------------------------------------------------
// lpgb_div
// Pipelined restoring divider, one quotient bit per stage, with a
// sideband that travels alongside.
// ----------------------------------------------------------------------------
module lpgb_div #(
    parameter int DW  = 17,
    parameter int DVW = 14,
    parameter int SW  = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [DVW-1:0]   divisor,
    input  logic             in_valid,
    input  logic [DW-1:0]    in_num,
    input  logic [SW-1:0]    in_side,
    output logic             out_valid,
    output logic [DW-1:0]    out_quot,
    output logic [SW-1:0]    out_side
);
    localparam int RW = DVW + 1;

    logic [DW:0]    valid_reg;
    logic [DW-1:0]  num_reg  [0:DW];
    logic [DW-1:0]  quot_reg [0:DW];
    logic [RW-1:0]  rem_reg  [0:DW];
    logic [SW-1:0]  side_reg [0:DW];

    // entry stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg[0]  <= in_num;
        quot_reg[0] <= '0;
        rem_reg[0]  <= '0;
        side_reg[0] <= in_side;
    end

    // one quotient bit per stage
    for (genvar k = 0; k < DW; k++) begin : g_step
        logic [RW-1:0] cur;
        logic          take;

        assign cur  = {rem_reg[k][RW-2:0], num_reg[k][DW-1]};
        assign take = (cur >= RW'(divisor));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            num_reg[k+1]  <= {num_reg[k][DW-2:0], 1'b0};
            rem_reg[k+1]  <= take ? (cur - RW'(divisor)) : cur;
            quot_reg[k+1] <= {quot_reg[k][DW-2:0], take};
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = valid_reg[DW];
    assign out_quot  = quot_reg[DW];
    assign out_side  = side_reg[DW];

endmodule
